// File: rtl/core/psg_pkg.sv
// psg_pkg: shared types, constants and lookup tables for the tone/noise sound generator
// depends on nothing; used by every module in rtl/core by scoped names
package psg_pkg;

   // number of square-tone voices that exist (1..3); voice slots above this stay silent
   localparam int unsigned TONE_VOICES = 3;
   localparam int unsigned LAST_VOICE  = TONE_VOICES - 1;
   localparam int unsigned CHANNELS    = 4;
   localparam int unsigned NOISE_CH    = 3;

   // transaction opcodes
   localparam logic [1:0] OP_REG_WRITE = 2'd0;
   localparam logic [1:0] OP_STEREO    = 2'd1;
   localparam logic [1:0] OP_TICK      = 2'd2;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TAP_MASK   = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LFSR_WIDTH = 1'b1;

   localparam logic [15:0] TAP_MASK_RESET = 16'h0009;
   localparam logic [3:0]  TOP_BIT_RESET  = 4'd15;
   localparam logic [3:0]  ATTEN_SILENT   = 4'hF;
   localparam logic [7:0]  STEREO_RESET   = 8'hFF;

   // noise rate select code that borrows the last tone voice's period
   localparam logic [1:0] NOISE_SEL_TONE = 2'd3;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] data;
   } psg_req_type;

   typedef struct packed {
      logic [14:0] left_sample;
      logic [14:0] right_sample;
   } psg_rsp_type;

   // per-voice update strobes from the register decoder
   typedef struct packed {
      logic       tick;
      logic       wr_lo;
      logic       wr_hi;
      logic [5:0] data;
   } psg_voice_ctl_type;

   // noise channel controls from the register decoder
   typedef struct packed {
      logic        tick;
      logic        ctl_write;
      logic [2:0]  ctl_data;
      logic [15:0] tap_mask;
      logic [3:0]  top_bit;
      logic        reseed;
      logic [3:0]  seed_bit;
   } psg_noise_ctl_type;

   // 2 dB steps, round(4096 * 10^(-k/10)), code 15 is off
   function automatic logic [12:0] level_rom(input logic [3:0] atten);
      logic [12:0] lvl;
      case (atten)
         4'd0:    lvl = 13'd4096;
         4'd1:    lvl = 13'd3254;
         4'd2:    lvl = 13'd2584;
         4'd3:    lvl = 13'd2053;
         4'd4:    lvl = 13'd1631;
         4'd5:    lvl = 13'd1295;
         4'd6:    lvl = 13'd1029;
         4'd7:    lvl = 13'd817;
         4'd8:    lvl = 13'd649;
         4'd9:    lvl = 13'd516;
         4'd10:   lvl = 13'd410;
         4'd11:   lvl = 13'd325;
         4'd12:   lvl = 13'd258;
         4'd13:   lvl = 13'd205;
         4'd14:   lvl = 13'd163;
         default: lvl = 13'd0;
      endcase
      return lvl;
   endfunction

   // fixed noise reload periods
   function automatic logic [9:0] noise_rate_period(input logic [1:0] sel);
      logic [9:0] val;
      case (sel)
         2'd0:    val = 10'd16;
         2'd1:    val = 10'd32;
         default: val = 10'd64;
      endcase
      return val;
   endfunction

   // lfsr length register value to feedback bit position; 0 acts as 1, above 16 as 16
   function automatic logic [3:0] top_bit_of(input logic [4:0] width);
      logic [3:0] tb;
      if (width == 5'd0) begin
         tb = 4'd0;
      end else if (width > 5'd16) begin
         tb = 4'd15;
      end else begin
         tb = 4'(width - 5'd1);
      end
      return tb;
   endfunction

endpackage

// File: rtl/core/psg_tone_voice.sv
// psg_tone_voice: one square-tone voice, period register, down-counter and output level
// depends on psg_pkg (psg_voice_ctl_type)
module psg_tone_voice (
   input  logic                        clock,
   input  logic                        reset,
   input  psg_pkg::psg_voice_ctl_type  ctl,
   output logic [9:0]                  period,
   output logic                        level
);

   logic [9:0] period_ff, period_in;
   logic [9:0] count_ff, count_in;
   logic       level_ff, level_in;

   always_comb begin
      period_in = period_ff;
      count_in  = count_ff;
      level_in  = level_ff;
      if (ctl.wr_lo) begin
         period_in = {period_ff[9:4], ctl.data[3:0]};
      end else if (ctl.wr_hi) begin
         period_in = {ctl.data, period_ff[3:0]};
      end
      if (ctl.tick) begin
         if (count_ff <= 10'd1) begin
            // zero period parks the output high
            level_in = (period_ff == 10'd0) ? 1'b1 : ~level_ff;
            count_in = period_ff;
         end else begin
            count_in = count_ff - 10'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= '0;
         count_ff  <= '0;
         level_ff  <= 1'b0;
      end else begin
         period_ff <= period_in;
         count_ff  <= count_in;
         level_ff  <= level_in;
      end
   end

   assign period = period_ff;
   assign level  = level_ff;

endmodule

// File: rtl/core/psg_noise.sv
// psg_noise: noise voice, rate divider, half-rate toggle and configurable lfsr
// depends on psg_pkg (psg_noise_ctl_type, noise_rate_period)
module psg_noise (
   input  logic                        clock,
   input  logic                        reset,
   input  psg_pkg::psg_noise_ctl_type  ctl,
   input  logic [9:0]                  tone_period,
   output logic                        level
);

   logic [2:0]  control_ff, control_in;
   logic [9:0]  count_ff, count_in;
   logic        half_ff, half_in;
   logic [15:0] shift_ff, shift_in;
   logic        level_ff, level_in;
   logic        feedback;

   always_comb begin
      control_in = control_ff;
      count_in   = count_ff;
      half_in    = half_ff;
      shift_in   = shift_ff;
      level_in   = level_ff;
      // white noise takes tap parity, periodic noise rotates bit 0 back in
      feedback   = control_ff[2] ? ^(shift_ff & ctl.tap_mask) : shift_ff[0];
      if (ctl.ctl_write) begin
         control_in = ctl.ctl_data;
      end
      if (ctl.tick) begin
         if (count_ff <= 10'd1) begin
            half_in = ~half_ff;
            if (!half_ff) begin
               level_in = shift_ff[0];
               shift_in = (shift_ff >> 1) | (16'(feedback) << ctl.top_bit);
            end
            count_in = (control_ff[1:0] == psg_pkg::NOISE_SEL_TONE) ? tone_period
                     : psg_pkg::noise_rate_period(control_ff[1:0]);
         end else begin
            count_in = count_ff - 10'd1;
         end
      end
      if (ctl.reseed) begin
         shift_in = 16'd1 << ctl.seed_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff <= '0;
         count_ff   <= '0;
         half_ff    <= 1'b0;
         shift_ff   <= 16'h8000;
         level_ff   <= 1'b0;
      end else begin
         control_ff <= control_in;
         count_ff   <= count_in;
         half_ff    <= half_in;
         shift_ff   <= shift_in;
         level_ff   <= level_in;
      end
   end

   assign level = level_ff;

endmodule

// File: rtl/core/psg_mixer.sv
// psg_mixer: attenuation lookup, stereo sums and the result register with its handshake
// depends on psg_pkg (psg_rsp_type, level_rom)
module psg_mixer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_accept,
   input  logic [3:0]           levels,
   input  logic [3:0]           atten [4],
   input  logic [7:0]           stereo,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output psg_pkg::psg_rsp_type rsp_payload
);

   logic                 pend_ff, pend_in;
   logic                 valid_ff, valid_in;
   psg_pkg::psg_rsp_type rsp_ff, rsp_in;
   logic                 rsp_load;
   logic [12:0]          ch_level [4];
   logic [14:0]          left_sum, right_sum;

   // pend_ff: state already updated by a transaction, sums not yet captured
   assign rsp_load  = pend_ff && (!valid_ff || !rsp_stall);
   assign req_stall = pend_ff && valid_ff && rsp_stall;

   always_comb begin
      left_sum  = '0;
      right_sum = '0;
      for (int c = 0; c < 4; c++) begin
         ch_level[c] = levels[c] ? psg_pkg::level_rom(atten[c]) : 13'd0;
         if (stereo[c]) begin
            left_sum = left_sum + 15'(ch_level[c]);
         end
         if (stereo[c+4]) begin
            right_sum = right_sum + 15'(ch_level[c]);
         end
      end
      rsp_in.left_sample  = left_sum;
      rsp_in.right_sample = right_sum;
      pend_in  = item_accept ? 1'b1 : (rsp_load ? 1'b0 : pend_ff);
      valid_in = rsp_load ? 1'b1 : ((valid_ff && !rsp_stall) ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         pend_ff  <= pend_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// File: rtl/core/psg_tone_noise_generator_core.sv
// psg_tone_noise_generator_core: top level of the four-voice tone/noise sound generator
// depends on psg_pkg, psg_tone_voice, psg_noise, psg_mixer
//
// Three square-tone voices plus one noise voice. Each request transaction is a
// register byte write (latch or data byte to tone period, noise control or
// attenuation), a stereo-enable byte write, or one generator tick. Every request
// returns exactly one response transaction with the left and right sums of the
// enabled channel levels as they stand after that request. The block takes one
// request per clock while req_stall is low: the request updates the voice state at
// its accepting edge, and the sums are then looked up and registered into the
// response register once it is free. One pending stage sits between state update
// and the response register, so a stalled response holds off only a request
// that would arrive while that stage is full. The configuration port (tap mask,
// lfsr length) is meant to be written while no transaction is in flight;
// writing the lfsr length reseeds the noise shift register with a single one at
// its feedback bit. Opcode 3 changes nothing and just returns the current sums.
module psg_tone_noise_generator_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  psg_pkg::psg_req_type                  req_payload,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output psg_pkg::psg_rsp_type                  rsp_payload,
   // configuration write port
   input  logic                                  csr_write,
   input  logic [psg_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [15:0]                           csr_wdata
);

   logic        item_accept;
   logic        is_reg_write, is_stereo, is_tick;
   logic        is_latch;

   // latched target is {attenuation select, channel}
   logic [2:0]  target_ff, target_in;
   logic [2:0]  target;
   logic [1:0]  target_ch;
   logic        ch_is_voice;

   logic [15:0] tap_mask_ff, tap_mask_in;
   logic [3:0]  top_bit_ff, top_bit_in;
   logic        reseed;
   logic [7:0]  stereo_ff, stereo_in;
   logic [3:0]  atten_ff [4];
   logic [3:0]  atten_in [4];

   psg_pkg::psg_voice_ctl_type voice_ctl [3];
   psg_pkg::psg_noise_ctl_type noise_ctl;
   logic [9:0]  voice_period [3];
   logic [3:0]  levels;

   assign item_accept = req_valid && !req_stall;

   // opcode decode
   always_comb begin
      is_reg_write = 1'b0;
      is_stereo    = 1'b0;
      is_tick      = 1'b0;
      unique case (req_payload.opcode)
         psg_pkg::OP_REG_WRITE: is_reg_write = item_accept;
         psg_pkg::OP_STEREO:    is_stereo    = item_accept;
         psg_pkg::OP_TICK:      is_tick      = item_accept;
         default: ;
      endcase
   end

   // latch byte (bit 7 set) retargets and writes the low nibble; data byte uses the latch
   assign is_latch    = req_payload.data[7];
   assign target      = is_latch ? {req_payload.data[4], req_payload.data[6:5]} : target_ff;
   assign target_ch   = target[1:0];
   assign ch_is_voice = int'(target_ch) < psg_pkg::TONE_VOICES;
   assign target_in   = (is_reg_write && is_latch) ? target : target_ff;

   always_comb begin
      tap_mask_in = tap_mask_ff;
      top_bit_in  = top_bit_ff;
      reseed      = 1'b0;
      if (csr_write) begin
         unique case (csr_index)
            psg_pkg::CSR_TAP_MASK: tap_mask_in = csr_wdata;
            psg_pkg::CSR_LFSR_WIDTH: begin
               top_bit_in = psg_pkg::top_bit_of(csr_wdata[4:0]);
               reseed     = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      stereo_in = is_stereo ? req_payload.data : stereo_ff;
      for (int c = 0; c < 4; c++) begin
         atten_in[c] = atten_ff[c];
      end
      // attenuation writes land only on existing voices and the noise channel
      if (is_reg_write && target[2] &&
          (ch_is_voice || int'(target_ch) == psg_pkg::NOISE_CH)) begin
         atten_in[target_ch] = req_payload.data[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff   <= '0;
         tap_mask_ff <= psg_pkg::TAP_MASK_RESET;
         top_bit_ff  <= psg_pkg::TOP_BIT_RESET;
         stereo_ff   <= psg_pkg::STEREO_RESET;
         for (int c = 0; c < 4; c++) begin
            atten_ff[c] <= psg_pkg::ATTEN_SILENT;
         end
      end else begin
         target_ff   <= target_in;
         tap_mask_ff <= tap_mask_in;
         top_bit_ff  <= top_bit_in;
         stereo_ff   <= stereo_in;
         for (int c = 0; c < 4; c++) begin
            atten_ff[c] <= atten_in[c];
         end
      end
   end

   // tone voices; slots above the configured count stay silent with a zero period
   for (genvar i = 0; i < 3; i++) begin : g_voice
      if (i < psg_pkg::TONE_VOICES) begin : g_on
         always_comb begin
            voice_ctl[i].tick  = is_tick;
            voice_ctl[i].wr_lo = is_reg_write && !target[2] && is_latch &&
                                 (int'(target_ch) == i);
            voice_ctl[i].wr_hi = is_reg_write && !target[2] && !is_latch &&
                                 (int'(target_ch) == i);
            voice_ctl[i].data  = req_payload.data[5:0];
         end

         psg_tone_voice u_voice (
            .clock  (clock),
            .reset  (reset),
            .ctl    (voice_ctl[i]),
            .period (voice_period[i]),
            .level  (levels[i])
         );
      end else begin : g_off
         assign voice_ctl[i]    = '0;
         assign voice_period[i] = (voice_ctl[i].tick) ? 10'd0 : 10'd0;
         assign levels[i]       = 1'b0;
      end
   end

   // noise voice
   always_comb begin
      noise_ctl.tick      = is_tick;
      noise_ctl.ctl_write = is_reg_write && !target[2] &&
                            (int'(target_ch) == psg_pkg::NOISE_CH);
      noise_ctl.ctl_data  = req_payload.data[2:0];
      noise_ctl.tap_mask  = tap_mask_ff;
      noise_ctl.top_bit   = top_bit_ff;
      noise_ctl.reseed    = reseed;
      noise_ctl.seed_bit  = top_bit_in;
   end

   psg_noise u_noise (
      .clock       (clock),
      .reset       (reset),
      .ctl         (noise_ctl),
      .tone_period (voice_period[psg_pkg::LAST_VOICE]),
      .level       (levels[psg_pkg::NOISE_CH])
   );

   // level lookup, stereo sums and response register
   psg_mixer u_mixer (
      .clock       (clock),
      .reset       (reset),
      .item_accept (item_accept),
      .levels      (levels),
      .atten       (atten_ff),
      .stereo      (stereo_ff),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
